### design/assert_macros.svh
// Shared assertion macros; clk and arst_n must be in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define BBD_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

`define BBD_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`define BBD_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### design/bbd_pkg.sv
package bbd_pkg;

	localparam int PIX_W       = 16;
	localparam int ROW_W       = 17;
	localparam int HEIGHT_W    = 16;
	localparam int WIDTH_REG_W = 14;
	localparam int MIN_WIDTH   = 64;
	localparam int MIN_HEIGHT  = 8;
	localparam int FIFO_DEPTH  = 4;

	localparam logic [1:0] CFG_LINE_WIDTH   = 2'd0;
	localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_CFA_PATTERN  = 2'd2;

	localparam logic CFA_RGGB = 1'b0;

	typedef struct packed {
		logic             mode;
		logic [PIX_W-1:0] raw_pixel;
	} pix_in_t;

	typedef struct packed {
		logic [PIX_W-1:0] red_value;
		logic [PIX_W-1:0] green_value;
		logic [PIX_W-1:0] blue_value;
		logic             line_end;
		logic             frame_end;
	} rgb_out_t;

	// position of the centre pixel for one accepted word
	typedef struct packed {
		logic emit;
		logic top_edge;
		logic bot_edge;
		logic left_edge;
		logic right_edge;
		logic rg_line;
		logic odd_col;
		logic last_frame;
	} pos_t;

endpackage

### design/bbd_ctrl.sv
`include "assert_macros.svh"

module bbd_ctrl
	import bbd_pkg::*;
#(
	parameter int MAX_LINE_WIDTH = 8192,
	localparam int WW = $clog2(MAX_LINE_WIDTH + 1),
	localparam int AW = $clog2(MAX_LINE_WIDTH)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	input  logic                acc,
	output logic [AW-1:0]       rd_idx,
	output pos_t                pos
);

	logic [WW-1:0]       eff_w_q;
	logic [HEIGHT_W-1:0] eff_h_q;
	logic                cfa_q;
	logic [WW-1:0]       col_q;
	logic [ROW_W-1:0]    row_q;

	logic [WIDTH_REG_W-1:0] lw;
	logic [WW-1:0]          w_new;
	logic [HEIGHT_W-1:0]    h_new;
	logic                   col_zero;
	logic [WW-1:0]          cc;
	logic [WW:0]            col_inc;
	logic                   wrap;
	logic                   neg;
	logic                   over;
	logic [ROW_W-1:0]       crow;
	logic [ROW_W-1:0]       hm1;

	assign lw = cfg_data[WIDTH_REG_W-1:0];

	always_comb begin
		if (lw < WIDTH_REG_W'(MIN_WIDTH)) begin
			w_new = WW'(MIN_WIDTH);
		end else if (32'(lw) > MAX_LINE_WIDTH) begin
			w_new = WW'(MAX_LINE_WIDTH);
		end else begin
			w_new = WW'(lw);
		end
	end

	assign h_new = (cfg_data < HEIGHT_W'(MIN_HEIGHT)) ? HEIGHT_W'(MIN_HEIGHT) : cfg_data;

	assign col_zero = (col_q == '0);
	assign cc       = col_zero ? (eff_w_q - WW'(1)) : (col_q - WW'(1));
	assign col_inc  = {1'b0, col_q} + (WW+1)'(1);
	assign wrap     = (col_inc >= {1'b0, eff_w_q});
	assign neg      = col_zero ? (row_q < ROW_W'(2)) : (row_q == '0);
	assign crow     = row_q - (col_zero ? ROW_W'(2) : ROW_W'(1));
	assign hm1      = {1'b0, eff_h_q} - ROW_W'(1);
	assign over     = !neg && (crow > hm1);

	always_comb begin
		pos.emit       = !neg && !over;
		pos.top_edge   = (crow == '0);
		pos.bot_edge   = (crow == hm1);
		pos.left_edge  = (cc == '0);
		pos.right_edge = (cc >= (eff_w_q - WW'(1)));
		pos.rg_line    = (crow[0] == cfa_q);
		pos.odd_col    = cc[0];
		pos.last_frame = pos.right_edge && pos.bot_edge;
	end

	assign rd_idx = col_q[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_w_q <= WW'(MIN_WIDTH);
			eff_h_q <= HEIGHT_W'(MIN_HEIGHT);
			cfa_q   <= CFA_RGGB;
			col_q   <= '0;
			row_q   <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_LINE_WIDTH:   eff_w_q <= w_new;
					CFG_FRAME_HEIGHT: eff_h_q <= h_new;
					CFG_CFA_PATTERN:  cfa_q   <= cfg_data[0];
					default: ;
				endcase
			end
			if (acc) begin
				if (over || (pos.emit && pos.last_frame)) begin
					col_q <= '0;
					row_q <= '0;
				end else if (wrap) begin
					col_q <= '0;
					row_q <= row_q + ROW_W'(1);
				end else begin
					col_q <= col_inc[WW-1:0];
				end
			end
		end
	end

	`BBD_ASSERT_NXT(a_frame_restart, acc && pos.emit && pos.last_frame, col_q == '0 && row_q == '0, "counters not cleared after frame end")

endmodule

### design/bbd_line_mem.sv
module bbd_line_mem
	import bbd_pkg::*;
#(
	parameter int MAX_LINE_WIDTH = 8192,
	parameter int PIXEL_BITS = 16,
	localparam int AW = $clog2(MAX_LINE_WIDTH)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  acc,
	input  logic [AW-1:0]         rd_idx,
	input  logic [PIXEL_BITS-1:0] px,
	output logic                  col_valid,
	output logic [PIXEL_BITS-1:0] col_up,
	output logic [PIXEL_BITS-1:0] col_mid,
	output logic [PIXEL_BITS-1:0] col_low
);

	logic [PIXEL_BITS-1:0] upper_mem  [MAX_LINE_WIDTH];
	logic [PIXEL_BITS-1:0] middle_mem [MAX_LINE_WIDTH];

	logic                  v_s1;
	logic                  fwd_s1;
	logic [AW-1:0]         idx_s1;
	logic [PIXEL_BITS-1:0] px_s1;
	logic [PIXEL_BITS-1:0] up_rd_s1;
	logic [PIXEL_BITS-1:0] mid_rd_s1;
	logic [PIXEL_BITS-1:0] fwd_up_s1;
	logic [PIXEL_BITS-1:0] fwd_mid_s1;
	logic [PIXEL_BITS-1:0] up_eff;
	logic [PIXEL_BITS-1:0] mid_eff;

	// same entry written back in the cycle it is read again
	assign up_eff  = fwd_s1 ? fwd_up_s1  : up_rd_s1;
	assign mid_eff = fwd_s1 ? fwd_mid_s1 : mid_rd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			fwd_s1 <= 1'b0;
		end else begin
			v_s1   <= acc;
			fwd_s1 <= acc && v_s1 && (rd_idx == idx_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			idx_s1     <= rd_idx;
			px_s1      <= px;
			up_rd_s1   <= upper_mem[rd_idx];
			mid_rd_s1  <= middle_mem[rd_idx];
			fwd_up_s1  <= mid_eff;
			fwd_mid_s1 <= px_s1;
		end
		if (v_s1) begin
			upper_mem[idx_s1]  <= mid_eff;
			middle_mem[idx_s1] <= px_s1;
		end
	end

	assign col_valid = v_s1;
	assign col_up    = up_eff;
	assign col_mid   = mid_eff;
	assign col_low   = px_s1;

endmodule

### design/bbd_window.sv
`include "assert_macros.svh"

module bbd_window
	import bbd_pkg::*;
#(
	parameter int PIXEL_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  acc,
	input  pos_t                  pos,
	input  logic                  col_valid,
	input  logic [PIXEL_BITS-1:0] col_up,
	input  logic [PIXEL_BITS-1:0] col_mid,
	input  logic [PIXEL_BITS-1:0] col_low,
	output logic                  stage2_valid,
	output logic                  push,
	output rgb_out_t              res
);

	logic [PIXEL_BITS-1:0] win_q [9];
	pos_t                  pos_s1;
	pos_t                  pos_s2;
	logic                  v_s2;

	logic [PIXEL_BITS-1:0] p [9];
	logic [PIXEL_BITS-1:0] own, lr, ud, diag, grn, r, g, b;

	function automatic logic [PIXEL_BITS-1:0] avg2(input logic [PIXEL_BITS-1:0] a,
			input logic [PIXEL_BITS-1:0] c);
		logic [PIXEL_BITS:0] s;
		s = {1'b0, a} + {1'b0, c} + (PIXEL_BITS+1)'(1);
		return s[PIXEL_BITS:1];
	endfunction

	always_ff @(posedge clk) begin
		if (acc) begin
			pos_s1 <= pos;
		end
		if (col_valid) begin
			pos_s2 <= pos_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
		end else begin
			v_s2 <= col_valid;
			if (col_valid) begin
				for (int k = 0; k < 3; k++) begin
					win_q[k*3]   <= win_q[k*3+1];
					win_q[k*3+1] <= win_q[k*3+2];
				end
				win_q[2] <= col_up;
				win_q[5] <= col_mid;
				win_q[8] <= col_low;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			p[i] = win_q[i];
		end
		if (pos_s2.top_edge) begin
			p[0] = '0; p[1] = '0; p[2] = '0;
		end
		if (pos_s2.bot_edge) begin
			p[6] = '0; p[7] = '0; p[8] = '0;
		end
		if (pos_s2.left_edge) begin
			p[0] = '0; p[3] = '0; p[6] = '0;
		end
		if (pos_s2.right_edge) begin
			p[2] = '0; p[5] = '0; p[8] = '0;
		end
	end

	assign own  = p[4];
	assign lr   = avg2(p[3], p[5]);
	assign ud   = avg2(p[1], p[7]);
	assign diag = avg2(avg2(p[0], p[2]), avg2(p[6], p[8]));
	assign grn  = avg2(ud, lr);

	always_comb begin
		if (pos_s2.rg_line) begin
			if (!pos_s2.odd_col) begin
				r = own; g = grn; b = diag;
			end else begin
				r = lr; g = own; b = ud;
			end
		end else begin
			if (!pos_s2.odd_col) begin
				r = ud; g = own; b = lr;
			end else begin
				r = diag; g = grn; b = own;
			end
		end
	end

	always_comb begin
		res.red_value   = PIX_W'(r);
		res.green_value = PIX_W'(g);
		res.blue_value  = PIX_W'(b);
		res.line_end    = pos_s2.right_edge;
		res.frame_end   = pos_s2.last_frame;
	end

	assign push         = v_s2 && pos_s2.emit;
	assign stage2_valid = v_s2;

	`BBD_ASSERT_IMP(a_s2_follows_s1, v_s2, $past(col_valid), "stage 2 valid without stage 1")
	`BBD_ASSERT_IMP(a_frame_end_line_end, push && res.frame_end, res.line_end, "frame end off line end")

endmodule

### design/bbd_out_fifo.sv
`include "assert_macros.svh"

module bbd_out_fifo
	import bbd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  rgb_out_t push_data,
	input  logic [1:0] inflight,
	output logic     credit,
	output logic     rgb_valid,
	input  logic     rgb_ready,
	output rgb_out_t rgb_data
);

	localparam int PW = $clog2(FIFO_DEPTH);
	localparam int CW = $clog2(FIFO_DEPTH + 1);

	rgb_out_t        mem_q [FIFO_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            pop;

	assign rgb_valid = (count_q != '0);
	assign rgb_data  = mem_q[rd_ptr_q];
	assign pop       = rgb_valid && rgb_ready;
	// room for every word still in the pipeline
	assign credit    = ({1'b0, count_q} + (CW+1)'(inflight)) < (CW+1)'(FIFO_DEPTH);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	`BBD_ASSERT_IMP(a_no_overflow, push && !pop, count_q < CW'(FIFO_DEPTH), "output queue overflow")

endmodule

### design/bayer_bilinear_demosaic.sv
// The result for a pixel is released by the word accepted W+1 words later (W = line width),
// then passes the line stores, window and output queue. Throughput: one word per cycle while
// credit allows, set by one read and one write per cycle on each line store.
// Reset: counters, window and output queue clear at once; line stores are not cleared,
// and registers return to width 64, height 8, RGGB.
`include "assert_macros.svh"

module bayer_bilinear_demosaic
	import bbd_pkg::*;
#(
	parameter int MAX_LINE_WIDTH = 8192,
	parameter int PIXEL_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pix_valid,
	output logic       pix_ready,
	input  pix_in_t    pix_data,
	output logic       rgb_valid,
	input  logic       rgb_ready,
	output rgb_out_t   rgb_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int AW = $clog2(MAX_LINE_WIDTH);

	logic                  acc;
	logic [PIXEL_BITS-1:0] px;
	logic [AW-1:0]         rd_idx;
	pos_t                  pos;
	logic                  col_valid;
	logic [PIXEL_BITS-1:0] col_up;
	logic [PIXEL_BITS-1:0] col_mid;
	logic [PIXEL_BITS-1:0] col_low;
	logic                  stage2_valid;
	logic                  push;
	rgb_out_t              res;
	logic [1:0]            inflight;
	logic                  credit;

	assign cfg_ready = 1'b1;
	assign pix_ready = credit;
	assign acc       = pix_valid && pix_ready;
	assign px        = pix_data.mode ? '0 : pix_data.raw_pixel[PIXEL_BITS-1:0];
	assign inflight  = 2'(col_valid) + 2'(stage2_valid);

	bbd_ctrl #(
		.MAX_LINE_WIDTH(MAX_LINE_WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.acc      (acc),
		.rd_idx   (rd_idx),
		.pos      (pos)
	);

	bbd_line_mem #(
		.MAX_LINE_WIDTH(MAX_LINE_WIDTH),
		.PIXEL_BITS    (PIXEL_BITS)
	) u_line_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (acc),
		.rd_idx   (rd_idx),
		.px       (px),
		.col_valid(col_valid),
		.col_up   (col_up),
		.col_mid  (col_mid),
		.col_low  (col_low)
	);

	bbd_window #(
		.PIXEL_BITS(PIXEL_BITS)
	) u_window (
		.clk         (clk),
		.arst_n      (arst_n),
		.acc         (acc),
		.pos         (pos),
		.col_valid   (col_valid),
		.col_up      (col_up),
		.col_mid     (col_mid),
		.col_low     (col_low),
		.stage2_valid(stage2_valid),
		.push        (push),
		.res         (res)
	);

	bbd_out_fifo u_out_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(res),
		.inflight (inflight),
		.credit   (credit),
		.rgb_valid(rgb_valid),
		.rgb_ready(rgb_ready),
		.rgb_data (rgb_data)
	);

	`BBD_ASSERT_NXT(a_s1_tracks_accept, acc, col_valid, "accepted word missing from stage 1")

endmodule
